// ===== design/rpnh_pkg.sv =====
package rpnh_pkg;

   localparam int POS_W  = 32;
   localparam int DIR_W  = 16;
   localparam int IDX_W  = 10;
   localparam int VCNT_W = 11;
   localparam int THR_W  = 16;
   localparam int CSR_W  = 16;
   localparam int OPD_W  = 33;
   localparam int PROD_W = 2 * OPD_W;
   localparam int ACC_W  = 120;
   localparam int DET_W  = 50;
   localparam int ADET_W = 49;
   localparam int TN_W   = 66;
   localparam int BT_W   = 65;
   localparam int NUM_W  = 82;
   localparam int MAG_W  = 41;
   localparam int SUM_W  = 43;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_PARALLEL_THR = 1'b1;

   localparam logic [MAG_W-1:0] HIT_CAP = MAG_W'(1) << 40;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // 32-bit limbs of a nonnegative t value, as signed multiplier operands
   function automatic logic signed [OPD_W-1:0] t_limb(input logic [BT_W-1:0] t,
                                                      input logic [1:0] i);
      logic signed [OPD_W-1:0] r;
      case (i)
         2'd0: r = {1'b0, t[31:0]};
         2'd1: r = {1'b0, t[63:32]};
         2'd2: r = {32'b0, t[64]};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [OPD_W-1:0] d_limb(input logic [ADET_W-1:0] d,
                                                      input logic i);
      logic signed [OPD_W-1:0] r;
      if (i) begin
         r = {16'b0, d[48:32]};
      end else begin
         r = {1'b0, d[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== design/rpnh_if.sv =====
interface rpnh_req_if import rpnh_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    op;
   logic [IDX_W-1:0]        vertex_index;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [DIR_W-1:0] dir_x;
   logic signed [DIR_W-1:0] dir_y;

   modport source (output valid, op, vertex_index, pos_x, pos_y, dir_x, dir_y,
                   input ready);
   modport sink (input valid, op, vertex_index, pos_x, pos_y, dir_x, dir_y,
                 output ready);
endinterface

interface rpnh_rsp_if import rpnh_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] hit_x;
   logic signed [POS_W-1:0] hit_y;
   logic                    hit_found;

   modport source (output valid, hit_x, hit_y, hit_found, input ready);
   modport sink (input valid, hit_x, hit_y, hit_found, output ready);
endinterface

// ===== design/ray_polyline_nearest_hit.sv =====
// Nearest crossing of a ray with a stored polyline.
// req_ch carries requests: op load writes vertex (pos_x, pos_y) into slot
// vertex_index (slots at or above MAX_VERTICES are dropped) and gives no
// response; op query casts a ray from (pos_x, pos_y) along (dir_x, dir_y)
// and gives one response on rsp_ch: the nearest hit point, or the origin
// with hit_found low. csr_we/csr_index/csr_wdata write vertex_count and
// parallel_threshold; write them only while the block is idle.
// A query walks segments one at a time on a single 33x33 multiplier feeding
// a 120-bit accumulator; a candidate is compared with the current best by
// cross multiplication only when a best is already held. With a hit, two
// restoring divisions, one per coordinate, give the point.
// req_ch.ready is high only while idle. A finished response sits in an
// output register; loads are still taken while it waits, and the next query
// completes only once rsp_ch.ready takes the previous response.
// Reset (synchronous) clears the state, counters, vertex_count, flow control and
// response valid and sets parallel_threshold to 1; vertex memory is not cleared and must be loaded before use.
module ray_polyline_nearest_hit import rpnh_pkg::*; #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   rpnh_req_if.sink         req_ch,
   rpnh_rsp_if.source       rsp_ch
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_F0, ST_F1, ST_F2, ST_DIFF, ST_DET1, ST_DET2, ST_U1, ST_U2,
      ST_T1, ST_T2, ST_TW, ST_CHK, ST_CMP, ST_CMPW, ST_CMPD, ST_NEXT,
      ST_NMUL, ST_NW1, ST_NW2, ST_DWAIT, ST_FIN
   } state_type;

   state_type state_ff;

   logic [VCNT_W-1:0] vcount_ff;
   logic [THR_W-1:0]  thr_ff;

   logic [POS_W-1:0] mem_x [MAX_VERTICES];
   logic [POS_W-1:0] mem_y [MAX_VERTICES];
   logic [POS_W-1:0] rd_x_ff, rd_y_ff;
   logic [AW-1:0]    rd_addr_ff;

   logic [CW-1:0] count_ff, seg_ff;
   logic [3:0]    k_ff;
   logic          sel_ff;
   logic          found_ff;

   logic signed [POS_W-1:0]  cx_ff, cy_ff, prev_x_ff, prev_y_ff, hx_ff, hy_ff;
   logic signed [DIR_W-1:0]  nx_ff, ny_ff;
   logic signed [OPD_W-1:0]  dx_ff, dy_ff, ex_ff, ey_ff;
   logic signed [DET_W-1:0]  det_ff, unum_ff;
   logic [BT_W-1:0]          cand_t_ff, best_t_ff;
   logic [ADET_W-1:0]        cand_det_ff, best_det_ff;

   logic                     rsp_valid_ff, rsp_found_ff;
   logic signed [POS_W-1:0]  rsp_x_ff, rsp_y_ff;

   // shared multiplier and accumulator
   logic signed [OPD_W-1:0]  mul_a, mul_b;
   acc_op_type               iss_op;
   logic                     iss_neg;
   logic [1:0]               iss_sh;
   logic signed [PROD_W-1:0] prod_ff;
   acc_op_type               pop_ff;
   logic                     pneg_ff;
   logic [1:0]               psh_ff;
   logic signed [ACC_W-1:0]  acc_ff, term, acc_in;

   div_status_type   div_st;
   logic [NUM_W-1:0] div_quo;
   logic             div_start;

   logic             accept;
   logic [31:0]      widx;
   logic [31:0]      cnt_eff;
   logic [31:0]      seg_next2;

   logic [2:0]       kk;
   logic             det_neg;
   logic [DET_W-1:0] adet_w;
   logic [ADET_W-1:0] adet;
   logic signed [TN_W-1:0]  tn;
   logic signed [DET_W-1:0] un;
   logic             hit_ok;
   logic             less;

   logic signed [POS_W-1:0] c_sel;
   logic signed [DIR_W-1:0] d_sel;
   logic signed [DIR_W:0]   d_ext;
   logic [DIR_W:0]          d_mag;
   logic                    q_over;
   logic [MAG_W-1:0]        m_val;
   logic signed [SUM_W-1:0] s_val;
   logic signed [POS_W-1:0] s_sat;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign widx         = 32'(req_ch.vertex_index);
   assign cnt_eff      = (32'(vcount_ff) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                               : 32'(vcount_ff);
   assign seg_next2    = 32'(seg_ff) + 32'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         thr_ff    <= THR_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_ff <= csr_wdata[VCNT_W-1:0];
            CSR_PARALLEL_THR: thr_ff    <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_ch.op == OP_LOAD && widx < 32'(MAX_VERTICES)) begin
         mem_x[widx[AW-1:0]] <= req_ch.pos_x;
         mem_y[widx[AW-1:0]] <= req_ch.pos_y;
      end
      rd_x_ff <= mem_x[rd_addr_ff];
      rd_y_ff <= mem_y[rd_addr_ff];
   end

   // segment test on the freshly accumulated t numerator
   always_comb begin
      det_neg = det_ff[DET_W-1];
      adet_w  = det_neg ? -det_ff : det_ff;
      adet    = adet_w[ADET_W-1:0];
      tn      = det_neg ? -acc_ff[TN_W-1:0] : acc_ff[TN_W-1:0];
      un      = det_neg ? -unum_ff : unum_ff;
      hit_ok  = (det_ff != '0) && (adet >= ADET_W'(thr_ff)) && !tn[TN_W-1]
                && !un[DET_W-1] && (DET_W'(un) <= {1'b0, adet});
      less    = acc_ff[ACC_W-1];
   end

   always_comb begin
      kk      = (k_ff < 4'd6) ? k_ff[2:0] : 3'(k_ff - 4'd6);
      c_sel   = sel_ff ? cy_ff : cx_ff;
      d_sel   = sel_ff ? ny_ff : nx_ff;
      d_ext   = {d_sel[DIR_W-1], d_sel};
      d_mag   = d_sel[DIR_W-1] ? DIR_W'(0) - d_ext : d_ext;
      mul_a   = '0;
      mul_b   = '0;
      iss_op  = ACC_NONE;
      iss_neg = 1'b0;
      iss_sh  = 2'd0;
      case (state_ff)
         ST_DET1: begin
            mul_a = {{(OPD_W-DIR_W){nx_ff[DIR_W-1]}}, nx_ff}; mul_b = dy_ff;
            iss_op = ACC_LOAD;
         end
         ST_DET2: begin
            mul_a = {{(OPD_W-DIR_W){ny_ff[DIR_W-1]}}, ny_ff}; mul_b = dx_ff;
            iss_op = ACC_ADD; iss_neg = 1'b1;
         end
         ST_U1: begin
            mul_a = ex_ff; mul_b = {{(OPD_W-DIR_W){ny_ff[DIR_W-1]}}, ny_ff};
            iss_op = ACC_LOAD;
         end
         ST_U2: begin
            mul_a = ey_ff; mul_b = {{(OPD_W-DIR_W){nx_ff[DIR_W-1]}}, nx_ff};
            iss_op = ACC_ADD; iss_neg = 1'b1;
         end
         ST_T1: begin
            mul_a = ex_ff; mul_b = dy_ff;
            iss_op = ACC_LOAD;
         end
         ST_T2: begin
            mul_a = ey_ff; mul_b = dx_ff;
            iss_op = ACC_ADD; iss_neg = 1'b1;
         end
         ST_CMP: begin
            // cand_t*best_det - best_t*cand_det, limb by limb
            if (k_ff < 4'd6) begin
               mul_a = t_limb(cand_t_ff, kk[2:1]);
               mul_b = d_limb(best_det_ff, kk[0]);
            end else begin
               mul_a = t_limb(best_t_ff, kk[2:1]);
               mul_b = d_limb(cand_det_ff, kk[0]);
            end
            iss_op  = (k_ff == 4'd0) ? ACC_LOAD : ACC_ADD;
            iss_neg = (k_ff >= 4'd6);
            iss_sh  = kk[2:1] + {1'b0, kk[0]};
         end
         ST_NMUL: begin
            mul_a  = t_limb(best_t_ff, k_ff[1:0]);
            mul_b  = OPD_W'(d_mag);
            iss_op = (k_ff == 4'd0) ? ACC_LOAD : ACC_ADD;
            iss_sh = k_ff[1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      term = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff} << {psh_ff, 5'b0};
      if (pneg_ff) begin
         term = -term;
      end
      case (pop_ff)
         ACC_LOAD: acc_in = term;
         ACC_ADD:  acc_in = acc_ff + term;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff <= ACC_NONE;
      end else begin
         pop_ff <= iss_op;
      end
      prod_ff <= mul_a * mul_b;
      pneg_ff <= iss_neg;
      psh_ff  <= iss_sh;
      acc_ff  <= acc_in;
   end

   assign div_start = (state_ff == ST_NW2);

   rpnh_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (acc_ff[NUM_W-1:0]),
      .den    (best_det_ff),
      .status (div_st),
      .quo    (div_quo)
   );

   // hit = origin + trunc(t*dir/det), magnitude capped, then saturated
   always_comb begin
      q_over = (|div_quo[NUM_W-1:MAG_W]) || (div_quo[MAG_W-1] && |div_quo[MAG_W-2:0]);
      m_val  = q_over ? HIT_CAP : div_quo[MAG_W-1:0];
      if (d_sel[DIR_W-1]) begin
         s_val = SUM_W'(c_sel) - SUM_W'({2'b0, m_val});
      end else begin
         s_val = SUM_W'(c_sel) + SUM_W'({2'b0, m_val});
      end
      if (s_val[SUM_W-1:POS_W-1] == '0 || s_val[SUM_W-1:POS_W-1] == '1) begin
         s_sat = s_val[POS_W-1:0];
      end else begin
         s_sat = s_val[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         k_ff         <= '0;
         sel_ff       <= 1'b0;
         seg_ff       <= '0;
         count_ff     <= '0;
         rd_addr_ff   <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_ch.op == OP_QUERY) begin
                  cx_ff      <= req_ch.pos_x;
                  cy_ff      <= req_ch.pos_y;
                  nx_ff      <= req_ch.dir_x;
                  ny_ff      <= req_ch.dir_y;
                  found_ff   <= 1'b0;
                  seg_ff     <= '0;
                  count_ff   <= cnt_eff[CW-1:0];
                  rd_addr_ff <= '0;
                  state_ff   <= (cnt_eff < 32'd2) ? ST_FIN : ST_F0;
               end
            end
            ST_F0: state_ff <= ST_F1;
            ST_F1: begin
               prev_x_ff  <= rd_x_ff;
               prev_y_ff  <= rd_y_ff;
               rd_addr_ff <= AW'(1);
               state_ff   <= ST_F2;
            end
            ST_F2: state_ff <= ST_DIFF;
            ST_DIFF: begin
               dx_ff      <= OPD_W'(signed'(rd_x_ff)) - OPD_W'(prev_x_ff);
               dy_ff      <= OPD_W'(signed'(rd_y_ff)) - OPD_W'(prev_y_ff);
               ex_ff      <= OPD_W'(prev_x_ff) - OPD_W'(cx_ff);
               ey_ff      <= OPD_W'(prev_y_ff) - OPD_W'(cy_ff);
               prev_x_ff  <= rd_x_ff;
               prev_y_ff  <= rd_y_ff;
               rd_addr_ff <= seg_next2[AW-1:0];
               state_ff   <= ST_DET1;
            end
            ST_DET1: state_ff <= ST_DET2;
            ST_DET2: state_ff <= ST_U1;
            ST_U1:   state_ff <= ST_U2;
            ST_U2: begin
               det_ff   <= acc_ff[DET_W-1:0];
               state_ff <= ST_T1;
            end
            ST_T1: state_ff <= ST_T2;
            ST_T2: begin
               unum_ff  <= acc_ff[DET_W-1:0];
               state_ff <= ST_TW;
            end
            ST_TW: state_ff <= ST_CHK;
            ST_CHK: begin
               cand_t_ff   <= tn[BT_W-1:0];
               cand_det_ff <= adet;
               k_ff        <= '0;
               if (!hit_ok) begin
                  state_ff <= ST_NEXT;
               end else if (!found_ff) begin
                  found_ff    <= 1'b1;
                  best_t_ff   <= tn[BT_W-1:0];
                  best_det_ff <= adet;
                  state_ff    <= ST_NEXT;
               end else begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               k_ff <= k_ff + 4'd1;
               if (k_ff == 4'd11) begin
                  state_ff <= ST_CMPW;
               end
            end
            ST_CMPW: state_ff <= ST_CMPD;
            ST_CMPD: begin
               if (less) begin
                  best_t_ff   <= cand_t_ff;
                  best_det_ff <= cand_det_ff;
               end
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               seg_ff <= seg_ff + 1'b1;
               k_ff   <= '0;
               sel_ff <= 1'b0;
               if (seg_next2 + 32'd1 <= 32'(count_ff)) begin
                  state_ff <= ST_DIFF;
               end else if (found_ff) begin
                  state_ff <= ST_NMUL;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_NMUL: begin
               k_ff <= k_ff + 4'd1;
               if (k_ff == 4'd2) begin
                  state_ff <= ST_NW1;
               end
            end
            ST_NW1: state_ff <= ST_NW2;
            ST_NW2: state_ff <= ST_DWAIT;
            ST_DWAIT: begin
               if (div_st.done) begin
                  k_ff <= '0;
                  if (sel_ff) begin
                     hy_ff    <= s_sat;
                     state_ff <= ST_FIN;
                  end else begin
                     hx_ff    <= s_sat;
                     sel_ff   <= 1'b1;
                     state_ff <= ST_NMUL;
                  end
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_x_ff     <= found_ff ? hx_ff : cx_ff;
                  rsp_y_ff     <= found_ff ? hy_ff : cy_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.hit_x     = rsp_x_ff;
   assign rsp_ch.hit_y     = rsp_y_ff;
   assign rsp_ch.hit_found = rsp_found_ff;

endmodule

// ===== design/rpnh_div.sv =====
module rpnh_div import rpnh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [ADET_W-1:0] den,
   output div_status_type    status,
   output logic [NUM_W-1:0]  quo
);

   localparam int CW = $clog2(NUM_W);

   logic [ADET_W-1:0] rem_ff;
   logic [ADET_W-1:0] den_ff;
   logic [NUM_W-1:0]  nq_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [ADET_W:0]   trial;
   logic              ge;
   logic [ADET_W:0]   diff;
   logic [ADET_W-1:0] rem_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, nq_ff[NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      diff   = trial - {1'b0, den_ff};
      rem_in = ge ? diff[ADET_W-1:0] : trial[ADET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            nq_ff   <= num;
            den_ff  <= den;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            nq_ff  <= {nq_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo         = nq_ff;

endmodule

// ===== dv/ray_polyline_nearest_hit_test.sv =====
module ray_polyline_nearest_hit_test import rpnh_pkg::*; ;

   class hit_scoreboard;
      typedef struct {
         logic signed [POS_W-1:0] x;
         logic signed [POS_W-1:0] y;
         logic                    found;
      } hit_type;
      typedef logic signed [159:0] wide_type;

      logic [POS_W-1:0] vx [1024];
      logic [POS_W-1:0] vy [1024];
      int unsigned      vcount;
      int unsigned      thr;
      hit_type          pending_hits[$];
      int               errors;

      function new();
         vcount = 0;
         thr    = 1;
         errors = 0;
      endfunction

      function void set_reg(logic idx, int unsigned value);
         if (idx == CSR_VERTEX_COUNT) begin
            vcount = value & 'h7FF;
         end else begin
            thr = value & 'hFFFF;
         end
      endfunction

      // origin + trunc(t*d/det), magnitude capped, sum saturated to 32 bits
      function logic signed [POS_W-1:0] project(longint c, wide_type t, longint det,
                                                longint d);
         wide_type m;
         wide_type s;
         m = (t * wide_type'(d < 0 ? -d : d)) / wide_type'(det);
         if (m > (wide_type'(1) << 40)) m = wide_type'(1) << 40;
         s = (d < 0) ? wide_type'(c) - m : wide_type'(c) + m;
         if (s > wide_type'($signed(32'h7FFF_FFFF))) s = wide_type'($signed(32'h7FFF_FFFF));
         if (s < wide_type'($signed(32'h8000_0000))) s = wide_type'($signed(32'h8000_0000));
         return s[POS_W-1:0];
      endfunction

      function void note_request(logic op, logic [IDX_W-1:0] idx,
                                 logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                                 logic signed [DIR_W-1:0] nx, logic signed [DIR_W-1:0] ny);
         hit_type  h;
         int       n;
         int       j;
         longint   cx, cy, dxn, dyn, x1, y1, dx, dy, ex, ey, det, adet, unum, bdet;
         wide_type tn, bt;
         logic     found;
         if (op == OP_LOAD) begin
            vx[idx] = px;
            vy[idx] = py;
            return;
         end
         cx = longint'(px); cy = longint'(py); dxn = longint'(nx); dyn = longint'(ny);
         n = (vcount > 1024) ? 1024 : vcount;
         found = 1'b0;
         bt = '0;
         bdet = 1;
         for (j = 0; j + 1 < n; j++) begin
            x1 = longint'($signed(vx[j]));
            y1 = longint'($signed(vy[j]));
            dx = longint'($signed(vx[j+1])) - x1;
            dy = longint'($signed(vy[j+1])) - y1;
            ex = x1 - cx;
            ey = y1 - cy;
            det = dxn * dy - dyn * dx;
            unum = ex * dyn - ey * dxn;
            adet = det < 0 ? -det : det;
            if (det == 0 || adet < longint'(thr)) continue;
            tn = wide_type'(ex) * wide_type'(dy) - wide_type'(ey) * wide_type'(dx);
            if (det < 0) begin
               tn = -tn;
               unum = -unum;
            end
            if (tn < 0 || unum < 0 || unum > adet) continue;
            // exact t comparison by cross multiplication; strict less keeps the earliest
            if (!found || tn * wide_type'(bdet) < bt * wide_type'(adet)) begin
               found = 1'b1;
               bt = tn;
               bdet = adet;
            end
         end
         if (found) begin
            h.x = project(cx, bt, bdet, dxn);
            h.y = project(cy, bt, bdet, dyn);
         end else begin
            h.x = px;
            h.y = py;
         end
         h.found = found;
         pending_hits.push_back(h);
      endfunction

      function void check_response(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                   logic found);
         hit_type h;
         if (pending_hits.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response x=%0d y=%0d found=%0b", x, y, found);
            return;
         end
         h = pending_hits.pop_front();
         if (x !== h.x || y !== h.y || found !== h.found) begin
            errors++;
            if (errors <= 10)
               $display("response mismatch: expected x=%0d y=%0d found=%0b, got x=%0d y=%0d found=%0b",
                        h.x, h.y, h.found, x, y, found);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;
   bit               calm;

   localparam logic signed [POS_W-1:0] PMAX  = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] PMIN  = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] TEN   = 32'sd655360;
   localparam logic signed [DIR_W-1:0] ONE   = 16'sd16384;
   localparam logic signed [DIR_W-1:0] DMAX  = 16'sh7FFF;
   localparam logic signed [DIR_W-1:0] DMIN  = 16'sh8000;

   rpnh_req_if req_ch ();
   rpnh_rsp_if rsp_ch ();
   hit_scoreboard sb = new();

   ray_polyline_nearest_hit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("ray_polyline_nearest_hit_test: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.hit_x, rsp_ch.hit_y, rsp_ch.hit_found);
   end

   // response back-pressure in bursts
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send(logic op, logic [IDX_W-1:0] idx,
                       logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                       logic signed [DIR_W-1:0] nx, logic signed [DIR_W-1:0] ny);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.vertex_index <= idx;
      req_ch.pos_x        <= px;
      req_ch.pos_y        <= py;
      req_ch.dir_x        <= nx;
      req_ch.dir_y        <= ny;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(op, idx, px, py, nx, ny);
   endtask

   task automatic load(logic [IDX_W-1:0] idx, logic signed [POS_W-1:0] px,
                       logic signed [POS_W-1:0] py);
      send(OP_LOAD, idx, px, py, DIR_W'($urandom), DIR_W'($urandom));
   endtask

   task automatic query(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                        logic signed [DIR_W-1:0] nx, logic signed [DIR_W-1:0] ny);
      send(OP_QUERY, IDX_W'($urandom), px, py, nx, ny);
   endtask

   // drop the request line and let the block go idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
      sb.set_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [POS_W-1:0] near(longint c, int unsigned r);
      longint v;
      v = c + longint'($urandom_range(0, 2 * r)) - longint'(r);
      if (v > longint'(PMAX)) v = longint'(PMAX);
      if (v < longint'(PMIN)) v = longint'(PMIN);
      return v[POS_W-1:0];
   endfunction

   function automatic int unsigned pick_radius();
      case ($urandom_range(0, 3))
         0: return 256;
         1: return 65536;
         2: return 1 << 24;
         default: return 1 << 30;
      endcase
   endfunction

   initial begin
      int          ph, i, n, k;
      int unsigned r;
      longint      ccx, ccy;

      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= CSR_VERTEX_COUNT;
      csr_wdata    <= '0;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_LOAD;
      req_ch.vertex_index <= '0;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.dir_x <= '0;
      req_ch.dir_y <= '0;
      calm = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no segments yet
      query(PMAX, PMIN, ONE, ONE);
      settle();
      write_csr(CSR_VERTEX_COUNT, 1);
      load(0, TEN, TEN);
      query(0, 0, DMIN, DMAX);
      settle();

      // closed square around the origin
      write_csr(CSR_VERTEX_COUNT, 5);
      load(0, -TEN, -TEN);
      load(1, TEN, -TEN);
      load(2, TEN, TEN);
      load(3, -TEN, TEN);
      load(4, -TEN, -TEN);
      query(0, 0, ONE, 0);
      query(0, 0, 0, DMIN);
      query(0, 0, DMAX, DMAX);        // corner: two segments tie
      query(0, 0, DMIN, DMIN);
      query(0, 0, 0, 0);              // zero direction
      query(2 * TEN, 0, ONE, 0);      // pointing away
      query(PMIN, 0, 1, 0);           // very large t
      query(TEN, 0, 0, ONE);          // origin on an edge
      query(PMAX, PMAX, DMIN, DMIN);
      settle();
      write_csr(CSR_PARALLEL_THR, 65535);
      query(0, 0, 1, 1);
      query(0, 0, ONE, 3);
      settle();
      write_csr(CSR_PARALLEL_THR, 0);

      // polyline at the coordinate extremes
      write_csr(CSR_VERTEX_COUNT, 3);
      load(0, PMAX, PMIN);
      load(1, PMAX, PMAX);
      load(2, PMIN, PMAX);
      query(PMIN, PMIN, ONE, ONE);
      query(PMIN, PMIN, DMAX, 1);
      query(0, 0, DMIN, DMAX);
      query(PMIN, 0, DMAX, DMIN);
      settle();

      // long polyline
      write_csr(CSR_PARALLEL_THR, 1);
      write_csr(CSR_VERTEX_COUNT, 128);
      for (i = 0; i < 128; i++) load(IDX_W'(i), near(0, 1 << 26), near(0, 1 << 26));
      query(near(0, 1 << 20), near(0, 1 << 20), DIR_W'($urandom), DIR_W'($urandom));
      query(near(0, 1 << 20), near(0, 1 << 20), DIR_W'($urandom), DIR_W'($urandom));
      settle();

      for (ph = 0; ph < 12; ph++) begin
         calm = (ph >= 10);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
         case ($urandom_range(0, 5))
            0: write_csr(CSR_PARALLEL_THR, 0);
            1: write_csr(CSR_PARALLEL_THR, 65535);
            2, 3: write_csr(CSR_PARALLEL_THR, 1);
            default: write_csr(CSR_PARALLEL_THR, $urandom_range(0, 65535));
         endcase
         write_csr(CSR_VERTEX_COUNT, n);
         r   = pick_radius();
         ccx = longint'(near(0, 1 << 28));
         ccy = longint'(near(0, 1 << 28));
         for (i = 0; i < n; i++) load(IDX_W'(i), near(ccx, r), near(ccy, r));
         for (i = 0; i < 23; i++) begin
            k = $urandom_range(0, 9);
            case (k)
               0, 1, 2, 3, 4, 5: query(near(ccx, r / 2), near(ccy, r / 2),
                                       DIR_W'($urandom), DIR_W'($urandom));
               6: query($urandom, $urandom, DIR_W'($urandom), DIR_W'($urandom));
               7: if (n > 0) load(IDX_W'($urandom_range(0, n - 1)),
                                  near(ccx, r), near(ccy, r));
               8: load(IDX_W'($urandom), $urandom, $urandom);
               default: query(near(ccx, r / 2), near(ccy, r / 2),
                              DIR_W'($urandom_range(0, 4) - 2),
                              DIR_W'($urandom_range(0, 4) - 2));
            endcase
         end
         settle();
      end

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
         $display("ray_polyline_nearest_hit_test: done, clean");
      end else begin
         $display("ray_polyline_nearest_hit_test: done, errors");
      end
      $finish;
   end
endmodule
